// ===== src/aca_pkg.sv =====
// Shared types and constants of the Aho-Corasick automaton.
package aca_pkg;

  localparam int unsigned DefNumStates    = 256;
  localparam int unsigned DefAlphabetSize = 26;
  localparam int unsigned QueueDepth      = 2;
  localparam logic [7:0]  LetterBase      = 8'd97;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  // Decoded request as it travels from the front end to the engine.
  typedef struct packed {
    req_e       req;
    logic [7:0] node;
    logic       letter_ok;
    logic [7:0] letter;
    logic       last_edge;
    logic       end_of_input;
  } cmd_t;

endpackage

// ===== src/aca_if.sv =====
// Request and result channel interfaces of the Aho-Corasick automaton.
interface aca_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] node;
  logic [7:0] symbol;
  logic       last_edge;
  logic       end_of_input;

  modport source (output valid, req_type, node, symbol, last_edge, end_of_input,
                  input ready);
  modport sink   (input valid, req_type, node, symbol, last_edge, end_of_input,
                  output ready);
endinterface

interface aca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] next_state;
  logic       build_done;
  logic       error;

  modport source (output valid, next_state, build_done, error, input ready);
  modport sink   (input valid, next_state, build_done, error, output ready);
endinterface

// ===== src/aca_front.sv =====
// Front end: accepts request beats and decodes the letter into a command.
module aca_front #(
  parameter int unsigned ALPHABET_SIZE = aca_pkg::DefAlphabetSize
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  aca_in_if.sink        in_i,
  output logic          cmd_valid_o,
  output aca_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);

  logic          vld_q;
  aca_pkg::cmd_t cmd_q;
  logic [7:0]    diff;
  logic          ok;

  assign diff = in_i.symbol - aca_pkg::LetterBase;
  assign ok   = (in_i.symbol >= aca_pkg::LetterBase) &&
                ({1'b0, diff} < 9'(ALPHABET_SIZE));

  assign in_i.ready  = enable_i && (!vld_q || cmd_ready_i);
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cmd_q <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        vld_q              <= 1'b1;
        cmd_q.req          <= aca_pkg::req_e'(in_i.req_type);
        cmd_q.node         <= in_i.node;
        cmd_q.letter_ok    <= ok;
        cmd_q.letter       <= diff;
        cmd_q.last_edge    <= in_i.last_edge;
        cmd_q.end_of_input <= in_i.end_of_input;
      end else if (cmd_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/aca_queue.sv =====
// Short command queue between the front end and the engine.
module aca_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  aca_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output aca_pkg::cmd_t pop_cmd_o,
  input  logic          pop_i
);

  localparam int unsigned PW = $clog2(aca_pkg::QueueDepth);

  aca_pkg::cmd_t mem_q [aca_pkg::QueueDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = cnt_q != (PW+1)'(aca_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(aca_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PW'(aca_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== src/aca_engine.sv =====
// Back end: goto, failure and queue memories, edge loads, build and steps.
module aca_engine #(
  parameter int unsigned NUM_STATES    = aca_pkg::DefNumStates,
  parameter int unsigned ALPHABET_SIZE = aca_pkg::DefAlphabetSize
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  aca_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          ready_o,
  aca_out_if.source     out_o
);

  localparam int unsigned SW   = $clog2(NUM_STATES);
  localparam int unsigned CNTW = SW + 1;
  localparam int unsigned LW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned EW   = SW + 1;
  localparam int unsigned RW   = ALPHABET_SIZE * EW;
  localparam int unsigned CMPW = (SW > 8) ? SW : 8;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EDGE, S_EDGE_WR, S_FCLR, S_ROOT_WR, S_ROOT_PUSH,
    S_POP, S_POP_WAIT, S_SROW, S_SCHK, S_WRD, S_WCHK, S_OUT
  } state_e;

  logic [RW-1:0] goto_mem [NUM_STATES];
  logic [SW-1:0] fail_mem [NUM_STATES];
  logic [SW-1:0] bfsq_mem [NUM_STATES];

  state_e        state_q;
  aca_pkg::cmd_t cmd_q;
  logic [SW-1:0] ec_q, cnt_q, s_q, t_q, ws_q;
  logic [LW-1:0] c_q;
  logic [CNTW-1:0] head_q, tail_q, n_q;
  logic          built_q, clr_edge_q, forced_q;
  logic [7:0]    next_q;
  logic          done_q, err_q;
  logic          ov_q;
  logic [7:0]    o_next_q;
  logic          o_done_q, o_err_q;

  logic [RW-1:0] row_q, row_wdata;
  logic [SW-1:0] frd_q, qrd_q;
  logic [SW-1:0] g_addr, g_waddr, f_addr, f_waddr, f_wdata, q_addr, q_wdata;
  logic          g_we, f_we, q_we;
  logic [EW-1:0] ent;
  logic          ent_v;
  logic [SW-1:0] ent_s;
  logic          last_c, can_push, edge_err, step_err, out_free;
  logic [SW-1:0] node_s, in_node_s;

  always_ff @(posedge clk_i) begin
    if (g_we) goto_mem[g_waddr] <= row_wdata;
    row_q <= goto_mem[g_addr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) fail_mem[f_waddr] <= f_wdata;
    frd_q <= fail_mem[f_addr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) bfsq_mem[tail_q[SW-1:0]] <= q_wdata;
    qrd_q <= bfsq_mem[q_addr];
  end

  assign ent      = row_q[32'(c_q) * EW +: EW];
  assign ent_v    = ent[EW-1];
  assign ent_s    = ent[SW-1:0];
  assign last_c   = c_q == LW'(ALPHABET_SIZE - 1);
  assign can_push = tail_q < CNTW'(NUM_STATES);
  assign node_s   = SW'(cmd_q.node);
  assign in_node_s = SW'(cmd_i.node);
  assign edge_err = !cmd_q.letter_ok || (CMPW'(cmd_q.node) > CMPW'(ec_q)) ||
                    (ec_q == SW'(NUM_STATES - 1));
  assign step_err = !built_q || !cmd_i.letter_ok || (CMPW'(cmd_i.node) > CMPW'(ec_q));
  assign out_free = !ov_q || out_o.ready;
  assign pop_o    = (state_q == S_IDLE) && cmd_valid_i;
  assign ready_o  = state_q != S_CLR;

  assign out_o.valid      = ov_q;
  assign out_o.next_state = o_next_q;
  assign out_o.build_done = o_done_q;
  assign out_o.error      = o_err_q;

  always_comb begin
    g_addr    = '0;
    g_we      = 1'b0;
    g_waddr   = cnt_q;
    row_wdata = '0;
    f_addr    = '0;
    f_we      = 1'b0;
    f_waddr   = cnt_q;
    f_wdata   = '0;
    q_addr    = head_q[SW-1:0];
    q_we      = 1'b0;
    q_wdata   = ent_s;
    unique case (state_q)
      S_CLR: g_we = 1'b1;
      S_EDGE: g_addr = node_s;
      S_EDGE_WR: begin
        g_we      = 1'b1;
        g_waddr   = node_s;
        row_wdata = row_q;
        row_wdata[32'(c_q) * EW +: EW] = {1'b1, ec_q + 1'b1};
      end
      S_FCLR: f_we = 1'b1;
      S_ROOT_WR: begin
        g_we      = 1'b1;
        g_waddr   = '0;
        row_wdata = row_q;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
          if (!row_q[i * EW + SW]) row_wdata[i * EW +: EW] = {1'b1, SW'(0)};
        end
      end
      S_ROOT_PUSH: q_we = (ent_s != '0) && can_push;
      S_SROW: begin
        g_addr = s_q;
        f_addr = s_q;
      end
      S_WRD: begin
        g_addr = ws_q;
        f_addr = ws_q;
      end
      S_WCHK: begin
        if ((ent_v || forced_q) && cmd_q.req == aca_pkg::REQ_EDGE) begin
          f_we    = 1'b1;
          f_waddr = t_q;
          f_wdata = ent_s;
          q_we    = can_push;
          q_wdata = t_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      cmd_q      <= '0;
      ec_q       <= '0;
      cnt_q      <= '0;
      s_q        <= '0;
      t_q        <= '0;
      ws_q       <= '0;
      c_q        <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      n_q        <= '0;
      built_q    <= 1'b0;
      clr_edge_q <= 1'b0;
      forced_q   <= 1'b0;
      next_q     <= '0;
      done_q     <= 1'b0;
      err_q      <= 1'b0;
      ov_q       <= 1'b0;
      o_next_q   <= '0;
      o_done_q   <= 1'b0;
      o_err_q    <= 1'b0;
    end else begin
      // In S_OUT the result register is refilled below whenever it is free.
      if (ov_q && out_o.ready && state_q != S_OUT) ov_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SW'(NUM_STATES - 1)) begin
            state_q <= clr_edge_q ? S_EDGE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q  <= cmd_i;
            c_q    <= cmd_i.letter[LW-1:0];
            next_q <= '0;
            done_q <= 1'b0;
            err_q  <= 1'b0;
            if (cmd_i.req == aca_pkg::REQ_EDGE) begin
              if (built_q) begin
                built_q    <= 1'b0;
                ec_q       <= '0;
                cnt_q      <= '0;
                clr_edge_q <= 1'b1;
                state_q    <= S_CLR;
              end else begin
                state_q <= S_EDGE;
              end
            end else if (step_err) begin
              err_q   <= 1'b1;
              state_q <= S_OUT;
            end else begin
              ws_q     <= in_node_s;
              n_q      <= '0;
              forced_q <= 1'b0;
              state_q  <= S_WRD;
            end
          end
        end
        S_EDGE: begin
          if (edge_err) begin
            err_q <= 1'b1;
            if (cmd_q.last_edge) begin
              cnt_q   <= '0;
              state_q <= S_FCLR;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            state_q <= S_EDGE_WR;
          end
        end
        S_EDGE_WR: begin
          ec_q <= ec_q + 1'b1;
          if (cmd_q.last_edge) begin
            cnt_q   <= '0;
            state_q <= S_FCLR;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_FCLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SW'(NUM_STATES - 1)) state_q <= S_ROOT_WR;
        end
        S_ROOT_WR: begin
          c_q     <= '0;
          head_q  <= '0;
          tail_q  <= '0;
          state_q <= S_ROOT_PUSH;
        end
        S_ROOT_PUSH: begin
          if (q_we) tail_q <= tail_q + 1'b1;
          if (last_c) state_q <= S_POP;
          else        c_q <= c_q + 1'b1;
        end
        S_POP: begin
          if (head_q < tail_q) begin
            head_q  <= head_q + 1'b1;
            state_q <= S_POP_WAIT;
          end else begin
            built_q <= 1'b1;
            done_q  <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_POP_WAIT: begin
          s_q     <= qrd_q;
          c_q     <= '0;
          state_q <= S_SROW;
        end
        S_SROW: state_q <= S_SCHK;
        S_SCHK: begin
          if (ent_v) begin
            t_q      <= ent_s;
            ws_q     <= frd_q;
            n_q      <= '0;
            forced_q <= 1'b0;
            state_q  <= S_WRD;
          end else if (last_c) begin
            state_q <= S_POP;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_SROW;
          end
        end
        S_WRD: state_q <= S_WCHK;
        S_WCHK: begin
          priority if (ent_v || forced_q) begin
            if (cmd_q.req == aca_pkg::REQ_STEP) begin
              next_q  <= (cmd_q.end_of_input && ws_q == '0) ? 8'd0 : 8'(ent_s);
              state_q <= S_OUT;
            end else begin
              if (q_we) tail_q <= tail_q + 1'b1;
              if (last_c) begin
                state_q <= S_POP;
              end else begin
                c_q     <= c_q + 1'b1;
                state_q <= S_SROW;
              end
            end
          end else if (n_q < CNTW'(NUM_STATES)) begin
            ws_q    <= frd_q;
            n_q     <= n_q + 1'b1;
            state_q <= S_WRD;
          end else begin
            ws_q     <= '0;
            forced_q <= 1'b1;
            state_q  <= S_WRD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_q       <= 1'b1;
            o_next_q   <= next_q;
            o_done_q   <= done_q;
            o_err_q    <= err_q;
            clr_edge_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/aho_corasick_automaton.sv =====
// Top level of the Aho-Corasick goto/failure automaton.
// Each request beat either loads one trie edge or steps the automaton by one character, and each
// request beat produces exactly one result beat. A front end registers and decodes requests and
// feeds a two-entry queue, so the request side keeps taking requests until the front register and
// the queue are full while the engine is busy or a result waits to be taken; it takes none while
// the engine clears its goto memory. The engine handles one request at a time from its goto row
// memory (one row of ALPHABET_SIZE entries per state), the failure-link memory and the
// breadth-first queue memory, all of them single-port reads with registered data. After reset
// the engine clears every row of the goto memory and takes no request meanwhile. The first edge
// after a finished build first clears the goto memory again. The edge marked last then runs the
// build: it clears the failure links, fills the empty entries of the root row and queues the
// root's children, then for every queued state reads its row letter by letter and, for every trie
// edge, follows failure links until a goto entry is found, writes the child's failure link and
// queues the child. A step follows failure links likewise, so its latency depends on the data.
module aho_corasick_automaton #(
  parameter int unsigned NUM_STATES    = aca_pkg::DefNumStates,
  parameter int unsigned ALPHABET_SIZE = aca_pkg::DefAlphabetSize
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aca_in_if.sink     in_i,
  aca_out_if.source  out_o
);

  logic          f_valid, f_ready;
  aca_pkg::cmd_t f_cmd;
  logic          q_valid, pop;
  aca_pkg::cmd_t q_cmd;
  logic          eng_ready;

  // Front end: request register and letter decoding.
  aca_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (eng_ready),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_ready)
  );

  // Decoupling queue between the two halves.
  aca_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_cmd_i   (f_cmd),
    .push_ready_o (f_ready),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd),
    .pop_i        (pop)
  );

  // Back end: table memories, build sequencer, failure walk and result register.
  aca_engine #(
    .NUM_STATES    (NUM_STATES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .ready_o     (eng_ready),
    .out_o       (out_o)
  );

endmodule
